@@ rtl/heading_speed_dead_reckoning_unit_macros.svh @@
// assertion helpers, sampled on the rising edge of clk, off while rst is high
`ifndef HEADING_SPEED_DEAD_RECKONING_UNIT_MACROS_SVH
`define HEADING_SPEED_DEAD_RECKONING_UNIT_MACROS_SVH

// same-cycle implication
`define HSDR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HSDR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/hsdr_pkg.sv @@
`default_nettype none
package hsdr_pkg;

  localparam int ANGLE_BITS_DEF = 16;

  // command and mode codes
  typedef enum logic [2:0] {
    CMD_STOP  = 3'd0,
    CMD_TURN  = 3'd1,
    CMD_ACCEL = 3'd2,
    CMD_MOVE  = 3'd3,
    CMD_DECEL = 3'd4
  } cmd_t;

  // register map, index into the 8-byte spaced map
  typedef enum logic [2:0] {
    REG_MAX_SPEED       = 3'd0,
    REG_ACCEL_DISTANCE  = 3'd1,
    REG_ANGULAR_SPEED   = 3'd2,
    REG_TURN_THRESHOLD  = 3'd3,
    REG_TIME_STEP       = 3'd4,
    REG_START_X         = 3'd5,
    REG_START_Y         = 3'd6,
    REG_INITIAL_HEADING = 3'd7
  } reg_t;

  typedef struct packed {
    logic        [30:0] max_speed;
    logic        [31:0] accel_distance;
    logic        [23:0] angular_speed;
    logic        [15:0] turn_threshold;
    logic        [15:0] time_step;
    logic signed [47:0] start_x;
    logic signed [47:0] start_y;
    logic        [15:0] initial_heading;
  } cfg_t;

  // state reloads that follow a write of a start register
  typedef struct packed {
    logic x;
    logic y;
    logic h;
  } cfg_load_t;

  localparam logic [30:0] MAX_SPEED_RST      = 31'd655360;
  localparam logic [31:0] ACCEL_DISTANCE_RST = 32'd655360;
  localparam logic [23:0] ANGULAR_SPEED_RST  = 24'd16384;
  localparam logic [15:0] TURN_THRESHOLD_RST = 16'd64;
  localparam logic [15:0] TIME_STEP_RST      = 16'd6554;

  // divider geometry
  localparam int DIV_NUM_W = 80;
  localparam int DIV_DEN_W = 62;
  localparam int DIV_Q_W   = 32;
  localparam int DIV_CNT_W = 7;

  // sine polynomial, q30
  localparam logic [30:0] Q30_ONE       = 31'h4000_0000;
  localparam logic [31:0] P_INIT        = 32'd3864;
  localparam int          HORNER_STEPS  = 5;

  localparam logic signed [49:0] POS_MAX = 50'sd140737488355327;
  localparam logic signed [49:0] POS_MIN = -50'sd140737488355328;

  function automatic logic [31:0] horner_coef(input logic [2:0] k);
    logic [31:0] c;
    case (k)
      3'd0:    c = 32'd172272;
      3'd1:    c = 32'd5026993;
      3'd2:    c = 32'd85569306;
      3'd3:    c = 32'd693598668;
      default: c = 32'd1686629713;
    endcase
    return c;
  endfunction

  // position step with saturation to the 48-bit signed range
  function automatic logic signed [47:0] pos_step(input logic signed [47:0] pos,
                                                  input logic [31:0] d,
                                                  input logic neg);
    logic signed [49:0] s;
    logic signed [49:0] p;
    logic signed [49:0] e;
    p = {{2{pos[47]}}, pos};
    e = $signed({18'b0, d});
    s = neg ? p - e : p + e;
    if (s > POS_MAX) begin
      s = POS_MAX;
    end else if (s < POS_MIN) begin
      s = POS_MIN;
    end
    return s[47:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/heading_speed_dead_reckoning_unit.sv @@
// one word at a time: no new word is taken until the result of the last one is
//   registered; the work is two 80-step runs of the one-bit restoring divider
//   and 24 passes through the 32x32 multiplier
// a finished result waits in the output register while the next word is taken
// reset: synchronous rst restores configuration registers, mode, speed, heading,
//   position and time at once; no clearing pass
`default_nettype none
`include "heading_speed_dead_reckoning_unit_macros.svh"
module heading_speed_dead_reckoning_unit
  import hsdr_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // configuration port
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [5:0]             paddr,
  input  wire logic [63:0]            pwdata,
  output logic      [63:0]            prdata,
  output logic                        pready,
  // tick words in
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [2:0]             command,
  input  wire logic [15:0]            target_heading,
  // telemetry words out
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic      [2:0]             mode,
  output logic      [ANGLE_BITS-1:0]  heading,
  output logic      [30:0]            speed,
  output logic      [31:0]            vel_x,
  output logic      [31:0]            vel_y,
  output logic      [47:0]            pos_x,
  output logic      [47:0]            pos_y,
  output logic      [47:0]            elapsed,
  output logic      [31:0]            stop_time
);

  // sequencer states
  typedef enum logic [6:0] {
    S_IDLE     = 7'b000_0001,
    S_ISSUE    = 7'b000_0010,
    S_WB       = 7'b000_0100,
    S_DIV_INC  = 7'b000_1000,
    S_UPD      = 7'b001_0000,
    S_DIV_STOP = 7'b010_0000,
    S_OUT      = 7'b100_0000
  } state_t;

  // multiplier micro-operations, in program order
  typedef enum logic [3:0] {
    OP_M2, OP_MT, OP_IL, OP_IH, OP_T2, OP_HORN, OP_PF,
    OP_DIST, OP_VX, OP_VY, OP_DX, OP_DY, OP_SV
  } op_t;

  cfg_t      cfg;
  cfg_load_t load;

  state_t state;
  op_t    op;
  logic   pass;        // low for the sine pass, high for the cosine pass
  logic [2:0] hk;      // horner step
  logic   div_go;

  // architectural state
  logic [2:0]             motion_mode;
  logic [30:0]            cur_speed;
  logic [ANGLE_BITS-1:0]  cur_heading;
  logic signed [47:0]     position_x;
  logic signed [47:0]     position_y;
  logic [47:0]            time_total;

  // working registers
  logic [2:0]             cmd_r;
  logic [ANGLE_BITS-1:0]  target_r;
  logic [61:0]            m2;
  logic [23:0]            mt;
  logic [47:0]            ilo;
  logic [77:0]            inc_num;
  logic [30:0]            inc;
  logic [30:0]            t2;
  logic [31:0]            p;
  logic [30:0]            s_val;
  logic [30:0]            c_val;
  logic [30:0]            step_len;
  logic [31:0]            vx;
  logic [31:0]            vy;
  logic [62:0]            sv_num;
  logic [31:0]            stop;

  // shared units
  logic [31:0]            mul_a;
  logic [31:0]            mul_b;
  logic [63:0]            prod;
  logic                   mul_en;
  logic [DIV_NUM_W-1:0]   div_num;
  logic [DIV_DEN_W-1:0]   div_den;
  logic [DIV_Q_W-1:0]     div_q;
  logic                   div_ovf;
  logic                   div_done;

  hsdr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .load    (load)
  );

  hsdr_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  hsdr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (div_num),
    .divisor  (div_den),
    .quot     (div_q),
    .ovf      (div_ovf),
    .done     (div_done)
  );

  // --------------------------------------------------------------------
  // combinational helpers
  // --------------------------------------------------------------------
  logic [31:0]            dc_eff;       // zero ramp distance counts as one
  logic [30:0]            v_stop;       // speed that the stop time is taken from
  logic [ANGLE_BITS-1:0]  raw_err;
  logic                   err_neg;      // a half-turn error turns clockwise
  logic [ANGLE_BITS-1:0]  err_mag;
  logic                   snap;
  logic [ANGLE_BITS-1:0]  slew;
  logic [ANGLE_BITS-1:0]  turn_heading;
  logic [31:0]            acc_sum;
  logic [30:0]            acc_speed;
  logic [30:0]            dec_speed;
  logic [48:0]            time_sum;
  logic [1:0]             quad;
  logic [29:0]            t30;
  logic [30:0]            u31;
  logic [30:0]            tt;
  logic [30:0]            pf_raw;
  logic [30:0]            pf_val;
  logic [30:0]            cosm;
  logic [30:0]            sinm;
  logic                   cneg;
  logic                   sneg;
  logic                   out_free;

  assign dc_eff = (cfg.accel_distance == '0) ? 32'd1 : cfg.accel_distance;

  always_comb begin
    if (motion_mode == CMD_MOVE) begin
      v_stop = cfg.max_speed;
    end else if ((motion_mode == CMD_ACCEL) || (motion_mode == CMD_DECEL)) begin
      v_stop = cur_speed;
    end else begin
      v_stop = '0;
    end
  end

  // heading error and slew limit
  always_comb begin
    raw_err = target_r - cur_heading;
    err_neg = raw_err[ANGLE_BITS-1];
    err_mag = err_neg ? (~raw_err + 1'b1) : raw_err;
    snap    = 25'(err_mag) <= 25'(cfg.turn_threshold);
    slew    = (25'(mt) < 25'(err_mag)) ? ANGLE_BITS'(mt) : err_mag;
    if (snap) begin
      turn_heading = target_r;
    end else if (err_neg) begin
      turn_heading = cur_heading - slew;
    end else begin
      turn_heading = cur_heading + slew;
    end
  end

  // ramp arithmetic and clock
  always_comb begin
    acc_sum   = {1'b0, cur_speed} + {1'b0, inc};
    acc_speed = (acc_sum >= {1'b0, cfg.max_speed}) ? cfg.max_speed : acc_sum[30:0];
    dec_speed = (cur_speed > inc) ? cur_speed - inc : '0;
    time_sum  = {1'b0, time_total} + 49'(cfg.time_step);
  end

  // quadrant split of the heading, fraction in q30 of a quarter turn
  always_comb begin
    quad   = cur_heading[ANGLE_BITS-1 -: 2];
    t30    = 30'({cur_heading[ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}});
    u31    = Q30_ONE - {1'b0, t30};
    tt     = pass ? u31 : {1'b0, t30};
    pf_raw = prod[60:30];
    pf_val = (pf_raw > Q30_ONE) ? Q30_ONE : pf_raw;
  end

  always_comb begin
    case (quad)
      2'd0: begin
        cosm = c_val; cneg = 1'b0; sinm = s_val; sneg = 1'b0;
      end
      2'd1: begin
        cosm = s_val; cneg = 1'b1; sinm = c_val; sneg = 1'b0;
      end
      2'd2: begin
        cosm = c_val; cneg = 1'b1; sinm = s_val; sneg = 1'b1;
      end
      default: begin
        cosm = s_val; cneg = 1'b0; sinm = c_val; sneg = 1'b1;
      end
    endcase
  end

  // multiplier operand select
  always_comb begin
    unique case (op)
      OP_M2:   begin mul_a = {1'b0, cfg.max_speed}; mul_b = {1'b0, cfg.max_speed}; end
      OP_MT:   begin mul_a = 32'(cfg.angular_speed); mul_b = 32'(cfg.time_step); end
      OP_IL:   begin mul_a = m2[31:0];              mul_b = 32'(cfg.time_step); end
      OP_IH:   begin mul_a = 32'(m2[61:32]);        mul_b = 32'(cfg.time_step); end
      OP_T2:   begin mul_a = 32'(tt);               mul_b = 32'(tt); end
      OP_HORN: begin mul_a = p;                     mul_b = 32'(t2); end
      OP_PF:   begin mul_a = p;                     mul_b = 32'(tt); end
      OP_DIST: begin mul_a = {1'b0, cur_speed};     mul_b = 32'(cfg.time_step); end
      OP_VX:   begin mul_a = {1'b0, cur_speed};     mul_b = 32'(cosm); end
      OP_VY:   begin mul_a = {1'b0, cur_speed};     mul_b = 32'(sinm); end
      OP_DX:   begin mul_a = {1'b0, step_len};      mul_b = 32'(cosm); end
      OP_DY:   begin mul_a = {1'b0, step_len};      mul_b = 32'(sinm); end
      OP_SV:   begin mul_a = {1'b0, v_stop};        mul_b = dc_eff; end
      default: begin mul_a = '0;                    mul_b = '0; end
    endcase
  end

  assign mul_en = (state == S_ISSUE);

  // divider operands: ramp step first, stop time second
  always_comb begin
    if (state == S_DIV_INC) begin
      div_num = {2'b00, inc_num};
      div_den = {13'b0, dc_eff, 17'b0};
    end else begin
      div_num = {sv_num, 17'b0};
      div_den = m2;
    end
  end

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // --------------------------------------------------------------------
  // sequencer and architectural state
  // --------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      op          <= OP_M2;
      pass        <= 1'b0;
      hk          <= '0;
      div_go      <= 1'b0;
      out_valid   <= 1'b0;
      motion_mode <= CMD_STOP;
      cur_speed   <= '0;
      cur_heading <= ANGLE_BITS'(cfg.initial_heading);
      position_x  <= cfg.start_x;
      position_y  <= cfg.start_y;
      time_total  <= '0;
    end else begin
      div_go <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_ISSUE;
            op    <= OP_M2;
          end
        end

        S_ISSUE: begin
          state <= S_WB;
        end

        S_WB: begin
          state <= S_ISSUE;
          unique case (op)
            OP_M2: op <= OP_MT;
            OP_MT: op <= OP_IL;
            OP_IL: op <= OP_IH;
            OP_IH: begin
              state  <= S_DIV_INC;
              div_go <= 1'b1;
            end
            OP_T2: begin
              hk <= '0;
              op <= OP_HORN;
            end
            OP_HORN: begin
              hk <= hk + 1'b1;
              if (hk == 3'(HORNER_STEPS - 1)) begin
                op <= OP_PF;
              end
            end
            OP_PF: begin
              if (!pass) begin
                pass <= 1'b1;
                op   <= OP_T2;
              end else begin
                op <= OP_DIST;
              end
            end
            OP_DIST: op <= OP_VX;
            OP_VX:   op <= OP_VY;
            OP_VY:   op <= OP_DX;
            OP_DX: begin
              position_x <= pos_step(position_x, prod[61:30], cneg);
              op         <= OP_DY;
            end
            OP_DY: begin
              position_y <= pos_step(position_y, prod[61:30], sneg);
              op         <= OP_SV;
            end
            OP_SV: begin
              state  <= S_DIV_STOP;
              div_go <= 1'b1;
            end
            default: state <= S_IDLE;
          endcase
        end

        S_DIV_INC: begin
          if (div_done) begin
            state <= S_UPD;
          end
        end

        // mode, speed, heading and clock move together
        S_UPD: begin
          case (cmd_r)
            CMD_STOP: begin
              motion_mode <= CMD_STOP;
              cur_speed   <= '0;
            end
            CMD_TURN: begin
              motion_mode <= CMD_TURN;
              cur_heading <= turn_heading;
            end
            CMD_ACCEL: begin
              motion_mode <= CMD_ACCEL;
              cur_speed   <= acc_speed;
            end
            CMD_MOVE: begin
              motion_mode <= CMD_MOVE;
              cur_speed   <= cfg.max_speed;
            end
            CMD_DECEL: begin
              motion_mode <= CMD_DECEL;
              cur_speed   <= dec_speed;
            end
            default: ;  // unknown command holds mode, speed and heading
          endcase
          time_total <= time_sum[48] ? '1 : time_sum[47:0];
          pass       <= 1'b0;
          op         <= OP_T2;
          state      <= S_ISSUE;
        end

        S_DIV_STOP: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end

        S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase

      // start register writes reload the matching state
      if (load.x) begin
        position_x <= cfg.start_x;
      end
      if (load.y) begin
        position_y <= cfg.start_y;
      end
      if (load.h) begin
        cur_heading <= ANGLE_BITS'(cfg.initial_heading);
      end
    end
  end

  // --------------------------------------------------------------------
  // working registers and output word
  // --------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && in_valid) begin
      cmd_r    <= command;
      target_r <= ANGLE_BITS'(target_heading);
    end

    if (state == S_WB) begin
      unique case (op)
        OP_M2:   m2      <= prod[61:0];
        OP_MT:   mt      <= prod[39:16];
        OP_IL:   ilo     <= prod[47:0];
        OP_IH:   inc_num <= {prod[45:0], 32'b0} + 78'(ilo);
        OP_T2: begin
          t2 <= prod[60:30];
          p  <= P_INIT;
        end
        OP_HORN: p <= horner_coef(hk) - prod[61:30];
        OP_PF: begin
          if (!pass) begin
            s_val <= pf_val;
          end else begin
            c_val <= pf_val;
          end
        end
        OP_DIST: step_len <= prod[46:16];
        OP_VX:   vx   <= cneg ? 32'd0 - {1'b0, prod[60:30]} : {1'b0, prod[60:30]};
        OP_VY:   vy   <= sneg ? 32'd0 - {1'b0, prod[60:30]} : {1'b0, prod[60:30]};
        OP_SV:   sv_num <= prod[62:0];
        default: ;
      endcase
    end

    // ramp step saturates at the top of the speed range
    if ((state == S_DIV_INC) && div_done) begin
      inc <= (div_ovf || div_q[31]) ? 31'h7FFF_FFFF : div_q[30:0];
    end

    if ((state == S_DIV_STOP) && div_done) begin
      if (v_stop == '0) begin
        stop <= '0;
      end else if ((m2 == '0) || div_ovf) begin
        stop <= '1;
      end else begin
        stop <= div_q;
      end
    end

    if ((state == S_OUT) && out_free) begin
      mode      <= motion_mode;
      heading   <= cur_heading;
      speed     <= cur_speed;
      vel_x     <= vx;
      vel_y     <= vy;
      pos_x     <= position_x;
      pos_y     <= position_y;
      elapsed   <= time_total;
      stop_time <= stop;
    end
  end

  // --------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------
  `HSDR_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
    "input taken while a tick is in progress")
  `HSDR_ASSERT_IMP(a_div_done_in_div_state, div_done,
    (state == S_DIV_INC) || (state == S_DIV_STOP), "divider finished outside a division")
  `HSDR_ASSERT_IMP(a_no_stop_time_at_rest,
    out_valid && ((mode == CMD_STOP) || (mode == CMD_TURN)), stop_time == '0,
    "stop time reported in stop or turn mode")

endmodule
`default_nettype wire

@@ rtl/hsdr_mul.sv @@
`default_nettype none
module hsdr_mul
  import hsdr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [63:0] prod
);

  // registered 32x32 unsigned product
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= 64'(a) * 64'(b);
    end
  end

endmodule
`default_nettype wire

@@ rtl/hsdr_div.sv @@
`default_nettype none
module hsdr_div
  import hsdr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [DIV_NUM_W-1:0] dividend,
  input  wire logic [DIV_DEN_W-1:0] divisor,
  output logic      [DIV_Q_W-1:0]   quot,
  output logic                      ovf,
  output logic                      done
);

  logic [DIV_NUM_W-1:0] num;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [DIV_DEN_W:0]   trial;
  logic                 take;
  logic [DIV_DEN_W-1:0] rem_next;

  // one restoring step per cycle
  always_comb begin
    trial    = {rem, num[DIV_NUM_W-1]};
    take     = trial >= {1'b0, divisor};
    rem_next = take ? DIV_DEN_W'(trial - {1'b0, divisor}) : trial[DIV_DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num  <= dividend;
      rem  <= '0;
      quot <= '0;
      ovf  <= 1'b0;
    end else if (busy) begin
      num  <= {num[DIV_NUM_W-2:0], 1'b0};
      rem  <= rem_next;
      quot <= {quot[DIV_Q_W-2:0], take};
      // quotient bits that fall off the top mean saturation
      ovf  <= ovf | quot[DIV_Q_W-1];
    end
  end

endmodule
`default_nettype wire

@@ rtl/hsdr_regs.sv @@
`default_nettype none
module hsdr_regs
  import hsdr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready,
  output cfg_t             cfg,
  output cfg_load_t        load
);

  logic wr;
  reg_t idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = reg_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_speed       <= MAX_SPEED_RST;
      cfg.accel_distance  <= ACCEL_DISTANCE_RST;
      cfg.angular_speed   <= ANGULAR_SPEED_RST;
      cfg.turn_threshold  <= TURN_THRESHOLD_RST;
      cfg.time_step       <= TIME_STEP_RST;
      cfg.start_x         <= '0;
      cfg.start_y         <= '0;
      cfg.initial_heading <= '0;
      load                <= '0;
    end else begin
      load <= '0;
      if (wr) begin
        unique case (idx)
          REG_MAX_SPEED:       cfg.max_speed      <= pwdata[30:0];
          REG_ACCEL_DISTANCE:  cfg.accel_distance <= pwdata[31:0];
          REG_ANGULAR_SPEED:   cfg.angular_speed  <= pwdata[23:0];
          REG_TURN_THRESHOLD:  cfg.turn_threshold <= pwdata[15:0];
          REG_TIME_STEP:       cfg.time_step      <= pwdata[15:0];
          REG_START_X: begin
            cfg.start_x <= $signed(pwdata[47:0]);
            load.x      <= 1'b1;
          end
          REG_START_Y: begin
            cfg.start_y <= $signed(pwdata[47:0]);
            load.y      <= 1'b1;
          end
          REG_INITIAL_HEADING: begin
            cfg.initial_heading <= pwdata[15:0];
            load.h              <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (idx)
      REG_MAX_SPEED:       prdata = 64'(cfg.max_speed);
      REG_ACCEL_DISTANCE:  prdata = 64'(cfg.accel_distance);
      REG_ANGULAR_SPEED:   prdata = 64'(cfg.angular_speed);
      REG_TURN_THRESHOLD:  prdata = 64'(cfg.turn_threshold);
      REG_TIME_STEP:       prdata = 64'(cfg.time_step);
      REG_START_X:         prdata = {{16{cfg.start_x[47]}}, cfg.start_x};
      REG_START_Y:         prdata = {{16{cfg.start_y[47]}}, cfg.start_y};
      REG_INITIAL_HEADING: prdata = 64'(cfg.initial_heading);
      default:             prdata = '0;
    endcase
  end

endmodule
`default_nettype wire
